// File: hw/rtl/stdl_pkg.sv
// stdl_pkg: shared constants, register indexes and lookup tables of the
// stereo tape delay. No dependencies; used by the interfaces and the top level.
package stdl_pkg;

  localparam int unsigned ADDR_BITS_DEF   = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WET_MIX,
    REG_BASE_DELAY,
    REG_DELAY_LIMIT,
    REG_FEEDBACK_GAIN,
    REG_WOBBLE_DEPTH,
    REG_DRIVE_GAIN,
    REG_DRIVE_NORM,
    REG_TONE_COEFF
  } reg_idx_e;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 24;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [22:0] SINE_CORR    = 23'd7373;
  localparam logic [22:0] LCG_MUL      = 23'd1664525;
  localparam logic [31:0] LCG_ADD      = 32'd1013904223;
  localparam logic [22:0] NOISE_GAIN   = 23'd983;
  localparam logic [22:0] WET_SCALE    = 23'd39322;
  localparam logic [16:0] BYPASS_BELOW = 17'd4711;
  localparam logic [16:0] MIX_FULL     = 17'd65536;

  // lfo phase increment per sample, in turns of 2^32
  function automatic logic [22:0] lfo_step(input logic [1:0] k);
    logic [22:0] v;
    case (k)
      2'd0:    v = 23'd546852;
      2'd1:    v = 23'd1572200;
      2'd2:    v = 23'd3896322;
      default: v = '0;
    endcase
    return v;
  endfunction

  // lfo weights, Q15
  function automatic logic [22:0] lfo_weight(input logic [1:0] k);
    logic [22:0] v;
    case (k)
      2'd0:    v = 23'd19661;
      2'd1:    v = 23'd9830;
      2'd2:    v = 23'd3277;
      default: v = '0;
    endcase
    return v;
  endfunction

  // tanh in steps of 0.25, Q0.23, held at the last entry
  function automatic logic [22:0] tanh_tab(input logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:    v = 23'd0;
      5'd1:    v = 23'd2054529;
      5'd2:    v = 23'd3876518;
      5'd3:    v = 23'd5328016;
      5'd4:    v = 23'd6388713;
      5'd5:    v = 23'd7115922;
      5'd6:    v = 23'd7592932;
      5'd7:    v = 23'd7896834;
      5'd8:    v = 23'd8086853;
      5'd9:    v = 23'd8204277;
      5'd10:   v = 23'd8276318;
      5'd11:   v = 23'd8319947;
      5'd12:   v = 23'd8347126;
      5'd13:   v = 23'd8363425;
      5'd14:   v = 23'd8373324;
      5'd15:   v = 23'd8379330;
      default: v = 23'd8382979;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/stdl_if.sv
// stdl_if: valid/ready stream interfaces for stereo sample pairs in and out.
// Depends on stdl_pkg for the default sample width.
interface stdl_in_if #(
  parameter int unsigned SAMPLE_BITS = stdl_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;

  modport source (output valid, in_left, in_right, input ready);
  modport sink   (input valid, in_left, in_right, output ready);
endinterface

interface stdl_out_if #(
  parameter int unsigned SAMPLE_BITS = stdl_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink   (input valid, out_left, out_right, output ready);
endinterface

// File: hw/rtl/stereo_tape_delay.sv
// stereo_tape_delay: stereo modulated feedback delay with lowpass and tanh
// saturation in the feedback path. Depends on stdl_pkg and the stdl_if streams.
//
// One stereo pair is accepted, worked on, and its output pair loaded into the
// output register before the next pair is taken. A finished pair waits to be
// loaded while the output side still holds an earlier result. The saturator
// steps are skipped when it is bypassed, and its table interpolation step when
// the drive is hard enough to hit the top of the tanh table. The sequencer
// steps one shared 34x24 signed multiplier, registered, through every product
// in turn: three lfo sines, the modulated delay, then per channel the
// interpolation, lowpass, saturator, feedback, noise and mix. Each channel
// keeps its delay line in a single-port style memory of 2^ADDR_BITS samples
// with registered reads. No clearing pass is needed after reset: writes walk
// the lines in order, so an entry counts as written when it lies below the
// write index or the index has wrapped once, and unwritten entries read as
// zero. Configuration writes are taken at any cycle but are meant only while
// no pair is in flight.
module stereo_tape_delay #(
  parameter int unsigned ADDR_BITS   = stdl_pkg::ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = stdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  stdl_in_if.sink                         in_ch,
  stdl_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [stdl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stdl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import stdl_pkg::*;

  localparam int unsigned S     = SAMPLE_BITS;
  localparam int unsigned F     = 32 - SAMPLE_BITS;   // lowpass extra fraction bits
  localparam int unsigned AW    = ADDR_BITS;
  localparam int unsigned DEPTH = 2 ** ADDR_BITS;
  localparam int unsigned LW    = (AW > 16) ? AW : 16; // width of the delay limit

  localparam logic signed [PROD_W-1:0] SMAX = (PROD_W'(1) <<< (S - 1)) - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] SMIN = -(PROD_W'(1) <<< (S - 1));

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,   // lfo sines
    ST_W0, ST_W1, ST_W2,                        // modulated delay
    ST_R0, ST_R1, ST_R2,                        // tap reads
    ST_C0, ST_C1, ST_C2,                        // interpolation and lowpass
    ST_C3, ST_C4, ST_C5, ST_C6,                 // saturator
    ST_FB, ST_N0, ST_N1, ST_N2,                 // feedback, noise, write-back
    ST_M1, ST_M2, ST_M3,                        // dry/wet mix
    ST_FIN
  } state_e;

  function automatic logic signed [S-1:0] sat_s(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] c;
    c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    return c[S-1:0];
  endfunction

  // configuration registers
  logic [16:0] wet_q;
  logic [23:0] base_q;
  logic [15:0] limit_q;
  logic [15:0] fbg_q;
  logic [10:0] wob_q;
  logic [16:0] drv_q;
  logic [15:0] norm_q;
  logic [15:0] tone_q;

  // sequencer and state
  state_e                state_q;
  logic [1:0]            k_q;
  logic                  ch_q;
  logic [AW-1:0]         wi_q;
  logic                  wrapped_q;
  logic [31:0]           seed_q;
  logic [31:0]           lp_q [2];
  logic                  out_valid_q;

  // working registers
  logic signed [S-1:0]        in_q   [2];
  logic signed [S-1:0]        a_q    [2];
  logic signed [S-1:0]        b_q    [2];
  logic signed [S-1:0]        ow_q   [2];
  logic signed [S-1:0]        out_l_q;
  logic signed [S-1:0]        out_r_q;
  logic signed [32:0]         acc_q;
  logic signed [17:0]         y_q;
  logic [AW-1:0]              i0_q;
  logic [7:0]                 fr_q;
  logic signed [S-1:0]        x_q;
  logic [22:0]                t_q;
  logic signed [S-1:0]        s_q;
  logic signed [S-1:0]        fbt_q;
  logic signed [PROD_W-1:0]   acc2_q;
  logic signed [PROD_W-1:0]   prod_q;

  // delay memories
  logic signed [S-1:0] mem_l [DEPTH];
  logic signed [S-1:0] mem_r [DEPTH];
  logic signed [S-1:0] rd_l_q;
  logic signed [S-1:0] rd_r_q;
  logic                rd_ok_q;

  logic                       in_xfer;
  logic                       out_load;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic [AW-1:0]              rd_addr;
  logic                       mem_re;
  logic                       mem_we;
  logic signed [S-1:0]        w_c;

  // combinational step values
  logic signed [16:0]   t17;
  logic signed [16:0]   t_abs;
  logic signed [17:0]   one_m_at;
  logic signed [17:0]   y_c;
  logic signed [17:0]   y_abs;
  logic signed [18:0]   sq_diff;
  logic signed [18:0]   sine_c;
  logic signed [18:0]   m2_c;
  logic signed [41:0]   mod_c;
  logic [LW-1:0]        lim_c;
  logic [LW+7:0]        mod_sel;
  logic [AW+7:0]        rp_c;
  logic [16:0]          wet_eff;
  logic signed [S-1:0]  a_c;
  logic signed [S-1:0]  b_c;
  logic signed [S-1:0]  in_c;
  logic signed [S-1:0]  rd_c;
  logic signed [31:0]   tgt_c;
  logic signed [32:0]   tdiff_c;
  logic [31:0]          lp_c;
  logic signed [S-1:0]  x_c;
  logic [S:0]           ax_c;
  logic [7:0]           tidx_c;
  logic [4:0]           tsel_c;
  logic signed [23:0]   tstep_c;
  logic [31:0]          t2_c;
  logic signed [34:0]   r_c;
  logic [31:0]          seed_c;
  logic                 bypass;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

  assign in_ch.ready      = (state_q == ST_IDLE);
  assign out_ch.valid     = out_valid_q;
  assign out_ch.out_left  = out_l_q;
  assign out_ch.out_right = out_r_q;

  assign bypass  = (drv_q < BYPASS_BELOW);
  assign wet_eff = (wet_q > MIX_FULL) ? MIX_FULL : wet_q;

  always_comb begin
    // sine steps
    t17      = 17'($signed(prod_q[31:16]));
    t_abs    = (t17 < 0) ? -t17 : t17;
    one_m_at = 18'sd32768 - 18'(t_abs);
    y_c      = $signed(prod_q[32:15]);
    y_abs    = (y_c < 0) ? -y_c : y_c;
    sq_diff  = 19'($signed(prod_q[32:15])) - 19'(y_q);
    sine_c   = 19'(y_q) + 19'($signed(prod_q[32:15]));
    // modulated delay, clamped to one sample and the limit
    m2_c     = 19'sd65536 + $signed(prod_q[33:15]);
    mod_c    = $signed(prod_q[57:16]);
    lim_c    = LW'(limit_q);
    if (lim_c == '0) begin
      lim_c = LW'(1);
    end
    if (lim_c > LW'(DEPTH - 2)) begin
      lim_c = LW'(DEPTH - 2);
    end
    if (mod_c < 42'sd256) begin
      mod_sel = (LW+8)'(256);
    end else if (mod_c > 42'($signed({1'b0, lim_c, 8'h00}))) begin
      mod_sel = {lim_c, 8'h00};
    end else begin
      mod_sel = mod_c[LW+7:0];
    end
    // wraps into the line by itself at this width
    rp_c     = {wi_q, 8'h00} - mod_sel[AW+7:0];
    // channel path
    a_c      = a_q[ch_q];
    b_c      = b_q[ch_q];
    in_c     = in_q[ch_q];
    rd_c     = S'((S+1)'(a_c) + $signed(prod_q[S+8:8]));
    tgt_c    = 32'(rd_c) <<< F;
    tdiff_c  = 33'(tgt_c) - 33'($signed(lp_q[ch_q]));
    lp_c     = 32'($signed(lp_q[ch_q]) + $signed(prod_q[49:16]));
    x_c      = $signed(lp_c[31:F]);
    ax_c     = (x_c < 0) ? -((S+1)'(x_c)) : (S+1)'(x_c);
    tidx_c   = prod_q[S+16:S+9];
    tsel_c   = {1'b0, tidx_c[3:0]};
    tstep_c  = $signed({1'b0, tanh_tab(tsel_c + 5'd1)}) - $signed({1'b0, tanh_tab(tsel_c)});
    t2_c     = 32'({t_q, 8'h00}) >> F;
    r_c      = $signed({1'b0, prod_q[48:15]});
    if (x_q < 0) begin
      r_c = -r_c;
    end
    seed_c   = prod_q[31:0] + LCG_ADD;
    w_c      = sat_s(PROD_W'(in_c) + PROD_W'(fbt_q) + PROD_W'($signed(prod_q[PROD_W-1:48-S])));
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_P0: begin
        mul_a = MUL_A_W'($signed({1'b0, wi_q}));
        mul_b = $signed({1'b0, lfo_step(k_q)});
      end
      ST_P1: begin
        mul_a = MUL_A_W'(t17) <<< 2;
        mul_b = MUL_B_W'(one_m_at);
      end
      ST_P2: begin
        mul_a = MUL_A_W'(y_c);
        mul_b = MUL_B_W'(y_abs);
      end
      ST_P3: begin
        mul_a = MUL_A_W'(sq_diff);
        mul_b = $signed({1'b0, SINE_CORR});
      end
      ST_P4: begin
        mul_a = MUL_A_W'(sine_c);
        mul_b = $signed({1'b0, lfo_weight(k_q)});
      end
      ST_W0: begin
        mul_a = MUL_A_W'($signed(acc_q[32:15]));
        mul_b = MUL_B_W'($signed({1'b0, wob_q}));
      end
      ST_W1: begin
        mul_a = MUL_A_W'($signed({1'b0, base_q}));
        mul_b = MUL_B_W'(m2_c);
      end
      ST_C0: begin
        mul_a = MUL_A_W'((S+1)'(b_c) - (S+1)'(a_c));
        mul_b = MUL_B_W'($signed({1'b0, fr_q}));
      end
      ST_C1: begin
        mul_a = MUL_A_W'(tdiff_c);
        mul_b = MUL_B_W'($signed({1'b0, tone_q}));
      end
      ST_C2: begin
        mul_a = MUL_A_W'($signed({1'b0, ax_c}));
        mul_b = MUL_B_W'($signed({1'b0, drv_q}));
      end
      ST_C3: begin
        mul_a = MUL_A_W'($signed({1'b0, prod_q[S+8:S-7]}));
        mul_b = tstep_c;
      end
      ST_C5: begin
        mul_a = MUL_A_W'($signed({1'b0, t2_c}));
        mul_b = MUL_B_W'($signed({1'b0, norm_q}));
      end
      ST_FB: begin
        mul_a = MUL_A_W'(s_q);
        mul_b = MUL_B_W'($signed({1'b0, fbg_q}));
      end
      ST_N0: begin
        mul_a = MUL_A_W'($signed({1'b0, seed_q}));
        mul_b = $signed({1'b0, LCG_MUL});
      end
      ST_N1: begin
        mul_a = MUL_A_W'($signed(seed_c));
        mul_b = $signed({1'b0, NOISE_GAIN});
      end
      ST_N2: begin
        mul_a = MUL_A_W'(s_q);
        mul_b = $signed({1'b0, WET_SCALE});
      end
      ST_M1: begin
        mul_a = MUL_A_W'($signed(prod_q[S+15:16]));
        mul_b = MUL_B_W'($signed({1'b0, wet_eff}));
      end
      ST_M2: begin
        mul_a = MUL_A_W'(in_c);
        mul_b = MUL_B_W'(18'sd65536 - $signed({1'b0, wet_eff}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // tap reads: lower tap then upper tap; one write per channel at the write index
  assign mem_re  = (state_q == ST_R0) || (state_q == ST_R1);
  assign rd_addr = (state_q == ST_R0) ? i0_q : (i0_q + AW'(1));
  assign mem_we  = (state_q == ST_N2);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (ch_q) begin
        mem_r[wi_q] <= w_c;
      end else begin
        mem_l[wi_q] <= w_c;
      end
    end
    if (mem_re) begin
      rd_l_q <= mem_l[rd_addr];
      rd_r_q <= mem_r[rd_addr];
    end
  end

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q   <= 17'd32768;
      base_q  <= 24'd7680000;
      limit_q <= 16'd57600;
      fbg_q   <= 16'd28836;
      wob_q   <= 11'd655;
      drv_q   <= 17'd4096;
      norm_q  <= 16'd32768;
      tone_q  <= 16'd25700;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WET_MIX:       wet_q   <= cfg_data_i[16:0];
        REG_BASE_DELAY:    base_q  <= cfg_data_i[23:0];
        REG_DELAY_LIMIT:   limit_q <= cfg_data_i[15:0];
        REG_FEEDBACK_GAIN: fbg_q   <= cfg_data_i[15:0];
        REG_WOBBLE_DEPTH:  wob_q   <= cfg_data_i[10:0];
        REG_DRIVE_GAIN:    drv_q   <= cfg_data_i[16:0];
        REG_DRIVE_NORM:    norm_q  <= cfg_data_i[15:0];
        REG_TONE_COEFF:    tone_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ch_q        <= 1'b0;
      wi_q        <= '0;
      wrapped_q   <= 1'b0;
      seed_q      <= '0;
      lp_q[0]     <= '0;
      lp_q[1]     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // output register: loaded from the sequencer, emptied by a transfer
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      // tap valid: written once the write index has passed it or wrapped
      if (mem_re) begin
        rd_ok_q <= wrapped_q || (rd_addr < wi_q);
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            in_q[0] <= in_ch.in_left;
            in_q[1] <= in_ch.in_right;
            k_q     <= '0;
            ch_q    <= 1'b0;
            acc_q   <= '0;
            state_q <= ST_P0;
          end
        end
        ST_P0: state_q <= ST_P1;
        ST_P1: state_q <= ST_P2;
        ST_P2: begin
          y_q     <= y_c;
          state_q <= ST_P3;
        end
        ST_P3: state_q <= ST_P4;
        ST_P4: state_q <= ST_P5;
        ST_P5: begin
          acc_q <= acc_q + $signed(prod_q[32:0]);
          if (k_q == 2'd2) begin
            state_q <= ST_W0;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_P0;
          end
        end
        ST_W0: state_q <= ST_W1;
        ST_W1: state_q <= ST_W2;
        ST_W2: begin
          i0_q    <= rp_c[AW+7:8];
          fr_q    <= rp_c[7:0];
          state_q <= ST_R0;
        end
        ST_R0: state_q <= ST_R1;
        ST_R1: begin
          a_q[0]  <= rd_ok_q ? rd_l_q : '0;
          a_q[1]  <= rd_ok_q ? rd_r_q : '0;
          state_q <= ST_R2;
        end
        ST_R2: begin
          b_q[0]  <= rd_ok_q ? rd_l_q : '0;
          b_q[1]  <= rd_ok_q ? rd_r_q : '0;
          state_q <= ST_C0;
        end
        ST_C0: state_q <= ST_C1;
        ST_C1: state_q <= ST_C2;
        ST_C2: begin
          lp_q[ch_q] <= lp_c;
          x_q        <= x_c;
          if (bypass) begin
            s_q     <= x_c;
            state_q <= ST_FB;
          end else begin
            state_q <= ST_C3;
          end
        end
        ST_C3: begin
          // drive of 4.0 and above holds at the top of the table
          if (tidx_c >= 8'd16) begin
            t_q     <= tanh_tab(5'd16);
            state_q <= ST_C5;
          end else begin
            t_q     <= tanh_tab(tsel_c);
            state_q <= ST_C4;
          end
        end
        ST_C4: begin
          t_q     <= t_q + prod_q[38:16];
          state_q <= ST_C5;
        end
        ST_C5: state_q <= ST_C6;
        ST_C6: begin
          s_q     <= sat_s(PROD_W'(r_c));
          state_q <= ST_FB;
        end
        ST_FB: state_q <= ST_N0;
        ST_N0: begin
          fbt_q   <= $signed(prod_q[S+15:16]);
          state_q <= ST_N1;
        end
        ST_N1: begin
          seed_q  <= seed_c;
          state_q <= ST_N2;
        end
        ST_N2: state_q <= ST_M1;
        ST_M1: state_q <= ST_M2;
        ST_M2: begin
          acc2_q  <= prod_q;
          state_q <= ST_M3;
        end
        ST_M3: begin
          ow_q[ch_q] <= sat_s((acc2_q + prod_q) >>> 16);
          if (ch_q) begin
            state_q <= ST_FIN;
          end else begin
            ch_q    <= 1'b1;
            state_q <= ST_C0;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            out_l_q     <= ow_q[0];
            out_r_q     <= ow_q[1];
            wi_q        <= wi_q + AW'(1);
            if (wi_q == '1) begin
              wrapped_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // the fill mark only ever grows
  assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(wrapped_q))
    else $error("delay line fill mark cleared");

  // the write position moves by one exactly when a result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (wi_q == $past(wi_q) + AW'(1)) && out_valid_q)
    else $error("write index did not advance with the result");

  // an input transfer starts the sequencer from the first lfo on the left channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_P0) && (k_q == 2'd0) && !ch_q)
    else $error("sequencer not restarted on input transfer");

  // results are never overwritten while waiting on the output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |=> $stable(out_l_q) && $stable(out_r_q))
    else $error("pending result overwritten");

endmodule
